FILE: design/cxy_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxy_pkg
// Shared constants, types and the restoring division step for the CoreXY
// move to motor step converter.
// ----------------------------------------------------------------------------
package cxy_pkg;

  localparam int NOZZLE_COUNT = 4;
  localparam int OPEN_W       = $clog2(NOZZLE_COUNT + 1);

  localparam int DXY_W = 34;
  localparam int DZ_W  = 33;
  localparam int DE_W  = 33;
  localparam int MAG_W = DE_W + OPEN_W;
  localparam int MH_W  = MAG_W - 32;
  localparam int PH_W  = MH_W + 33;

  localparam int DUR_STEPS  = 32;
  localparam int RATE_W     = 40;
  localparam int RATE_STEPS = RATE_W;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_XY = 2'd0;
  localparam logic [1:0] REG_Z  = 2'd1;
  localparam logic [1:0] REG_E  = 2'd2;

  typedef struct packed {
    logic signed [DXY_W-1:0] da;
    logic signed [DXY_W-1:0] db;
    logic signed [DZ_W-1:0]  dz;
    logic signed [DE_W-1:0]  de;
    logic [OPEN_W-1:0]       n_open;
    logic [7:0]              mask;
  } move_t;

  typedef struct packed {
    move_t       mv;
    logic [31:0] dur;
  } q_entry_t;

  typedef struct packed {
    logic [31:0] xy;
    logic [31:0] z;
    logic [31:0] e;
  } spm_t;

  typedef struct packed {
    logic push;
  } q_wr_t;

  typedef struct packed {
    logic [31:0] rem;
    logic        q;
  } div_res_t;

  function automatic div_res_t div_step(input logic [31:0] rem, input logic b,
                                        input logic [31:0] d);
    logic [32:0] t;
    logic [32:0] s;
    div_res_t    r;
    t = {rem, b};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      r.rem = s[31:0];
      r.q   = 1'b1;
    end else begin
      r.rem = t[31:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: design/cxy_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxy_front
// Accepts moves, forms the axis deltas and nozzle count, and runs the move
// duration through a one-bit-per-stage pipelined divider.
// ----------------------------------------------------------------------------
module cxy_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [31:0]    start_x_i,
  input  logic signed [31:0]    start_y_i,
  input  logic signed [31:0]    start_z_i,
  input  logic signed [31:0]    start_e_i,
  input  logic signed [31:0]    end_x_i,
  input  logic signed [31:0]    end_y_i,
  input  logic signed [31:0]    end_z_i,
  input  logic signed [31:0]    end_e_i,
  input  logic [31:0]           path_length_i,
  input  logic [31:0]           feed_speed_i,
  input  logic [7:0]            nozzle_mask_i,
  output cxy_pkg::q_wr_t        wr_o,
  input  logic                  full_i,
  output cxy_pkg::q_entry_t     entry_o
);
  import cxy_pkg::*;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] bits;
    logic [31:0] spd;
    logic        sat;
    logic        zero;
    move_t       mv;
  } fstage_t;

  fstage_t              st_q [DUR_STEPS];
  fstage_t              st_d [DUR_STEPS];
  logic [DUR_STEPS-1:0] v_q;
  logic                 adv;
  logic [32:0]          dx, dy, dz, de;
  logic [OPEN_W-1:0]    n_open;
  div_res_t             r0, ri;
  fstage_t              last;

  assign last       = st_q[DUR_STEPS-1];
  assign adv        = !v_q[DUR_STEPS-1] || !full_i;
  assign in_stall_o = !adv;

  always_comb begin
    dx = {end_x_i[31], end_x_i} - {start_x_i[31], start_x_i};
    dy = {end_y_i[31], end_y_i} - {start_y_i[31], start_y_i};
    dz = {end_z_i[31], end_z_i} - {start_z_i[31], start_z_i};
    de = {end_e_i[31], end_e_i} - {start_e_i[31], start_e_i};
    n_open = '0;
    for (int k = 0; k < NOZZLE_COUNT; k++) begin
      n_open = n_open + OPEN_W'(nozzle_mask_i[k]);
    end
    if (n_open == '0) begin
      n_open = OPEN_W'(1);
    end
    r0 = div_step({16'h0, path_length_i[31:16]}, path_length_i[15], feed_speed_i);
    st_d[0].rem       = r0.rem;
    st_d[0].quo       = {31'h0, r0.q};
    st_d[0].bits      = {path_length_i[14:0], 17'h0};
    st_d[0].spd       = feed_speed_i;
    st_d[0].sat       = {16'h0, path_length_i[31:16]} >= feed_speed_i;
    st_d[0].zero      = (path_length_i == '0) || (feed_speed_i == '0);
    st_d[0].mv.da     = {dx[32], dx} + {dy[32], dy};
    st_d[0].mv.db     = {dx[32], dx} - {dy[32], dy};
    st_d[0].mv.dz     = dz;
    st_d[0].mv.de     = de;
    st_d[0].mv.n_open = n_open;
    st_d[0].mv.mask   = nozzle_mask_i;
    ri = '0;
    for (int i = 1; i < DUR_STEPS; i++) begin
      ri = div_step(st_q[i-1].rem, st_q[i-1].bits[31], st_q[i-1].spd);
      st_d[i]      = st_q[i-1];
      st_d[i].rem  = ri.rem;
      st_d[i].quo  = {st_q[i-1].quo[30:0], ri.q};
      st_d[i].bits = {st_q[i-1].bits[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[DUR_STEPS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= st_d;
    end
  end

  assign wr_o.push = v_q[DUR_STEPS-1] && !full_i;
  assign entry_o.mv  = last.mv;
  assign entry_o.dur = last.zero ? 32'h0 : (last.sat ? 32'hFFFF_FFFF : last.quo);

endmodule

FILE: design/cxy_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxy_queue
// Short first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module cxy_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cxy_pkg::q_wr_t    wr_i,
  input  cxy_pkg::q_entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output cxy_pkg::q_entry_t entry_o
);
  import cxy_pkg::*;

  q_entry_t        mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_AW:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = wr_i.push && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: design/cxy_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxy_back
// Scales the deltas to steps with rounding and saturation, then divides the
// exact step products by the duration in four pipelined rate dividers.
// ----------------------------------------------------------------------------
module cxy_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cxy_pkg::spm_t        spm_i,
  input  logic                 empty_i,
  input  cxy_pkg::q_entry_t    entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          move_time_o,
  output logic signed [31:0]   motor_a_steps_o,
  output logic [39:0]          motor_a_rate_o,
  output logic signed [31:0]   motor_b_steps_o,
  output logic [39:0]          motor_b_rate_o,
  output logic signed [31:0]   z_steps_o,
  output logic [39:0]          z_rate_o,
  output logic signed [31:0]   extruder_steps_o,
  output logic [39:0]          extruder_rate_o,
  output logic [7:0]           valve_bits_o
);
  import cxy_pkg::*;

  localparam int NB = RATE_STEPS + 3;

  typedef struct packed {
    logic [31:0]                 dur;
    logic [7:0]                  mask;
    logic [3:0][31:0]            steps;
    logic [3:0]                  zero;
    logic [3:0]                  sat;
    logic [3:0][31:0]            rem;
    logic [3:0][RATE_STEPS-1:0]  quo;
    logic [3:0][RATE_STEPS-1:0]  bits;
  } rstage_t;

  function automatic rstage_t rate_step(input rstage_t s);
    rstage_t  o;
    div_res_t r;
    o = s;
    for (int a = 0; a < 4; a++) begin
      r         = div_step(s.rem[a], s.bits[a][RATE_STEPS-1], s.dur);
      o.rem[a]  = r.rem;
      o.quo[a]  = {s.quo[a][RATE_STEPS-2:0], r.q};
      o.bits[a] = {s.bits[a][RATE_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

  logic                      adv;
  logic [NB-1:0]             bv_q;
  logic                      out_v_q;
  logic [3:0][31:0]          spm_ax;
  logic [3:0][MAG_W-1:0]     vals;
  logic signed [MAG_W-1:0]   de_s;

  logic [3:0]                b0_neg_q, b0_neg_d;
  logic [3:0][MAG_W-1:0]     b0_mag_q, b0_mag_d;
  logic [31:0]               b0_dur_q;
  logic [7:0]                b0_mask_q;

  logic [3:0]                b1_neg_q;
  logic [3:0][63:0]          b1_lo_q, b1_lo_d;
  logic [3:0][MH_W+31:0]     b1_hi_q, b1_hi_d;
  logic [31:0]               b1_dur_q;
  logic [7:0]                b1_mask_q;

  rstage_t                   b2_q, b2_d;
  rstage_t                   rs_q [RATE_STEPS];
  rstage_t                   rs_d [RATE_STEPS];
  rstage_t                   fin;
  logic [PH_W-1:0]           ph, smag;

  logic [31:0]               time_q;
  logic [3:0][31:0]          steps_q;
  logic [3:0][RATE_W-1:0]    rate_q, rate_d;
  logic [7:0]                mask_q;

  assign adv   = !out_v_q || !out_stall_i;
  assign pop_o = adv && !empty_i;
  assign fin   = rs_q[RATE_STEPS-1];

  assign spm_ax[0] = spm_i.xy;
  assign spm_ax[1] = spm_i.xy;
  assign spm_ax[2] = spm_i.z;
  assign spm_ax[3] = spm_i.e;

  always_comb begin
    de_s = $signed({{OPEN_W{entry_i.mv.de[DE_W-1]}}, entry_i.mv.de})
         * $signed({1'b0, entry_i.mv.n_open});
    vals[0] = {{(MAG_W-DXY_W){entry_i.mv.da[DXY_W-1]}}, entry_i.mv.da};
    vals[1] = {{(MAG_W-DXY_W){entry_i.mv.db[DXY_W-1]}}, entry_i.mv.db};
    vals[2] = {{(MAG_W-DZ_W){entry_i.mv.dz[DZ_W-1]}}, entry_i.mv.dz};
    vals[3] = de_s;
    for (int a = 0; a < 4; a++) begin
      b0_neg_d[a] = vals[a][MAG_W-1];
      b0_mag_d[a] = vals[a][MAG_W-1] ? (~vals[a] + 1'b1) : vals[a];
      b1_lo_d[a]  = b0_mag_q[a][31:0] * spm_ax[a];
      b1_hi_d[a]  = b0_mag_q[a][MAG_W-1:32] * spm_ax[a];
    end
  end

  always_comb begin
    b2_d      = '0;
    b2_d.dur  = b1_dur_q;
    b2_d.mask = b1_mask_q;
    ph        = '0;
    smag      = '0;
    for (int a = 0; a < 4; a++) begin
      ph   = PH_W'(b1_lo_q[a][63:32]) + PH_W'(b1_hi_q[a]);
      smag = ph + PH_W'(b1_lo_q[a][31]);
      if (b1_neg_q[a]) begin
        b2_d.steps[a] = (smag >= PH_W'(32'h8000_0000)) ? 32'h8000_0000
                                                        : (32'h0 - smag[31:0]);
      end else begin
        b2_d.steps[a] = (smag >= PH_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : smag[31:0];
      end
      b2_d.zero[a] = (b1_dur_q == '0) || (smag == '0);
      b2_d.sat[a]  = RATE_W'(ph) >= {b1_dur_q, 8'h0};
      b2_d.rem[a]  = 32'(ph[PH_W-1:8]);
      b2_d.bits[a] = {ph[7:0], b1_lo_q[a][31:0]};
    end
    rs_d[0] = rate_step(b2_q);
    for (int k = 1; k < RATE_STEPS; k++) begin
      rs_d[k] = rate_step(rs_q[k-1]);
    end
    for (int a = 0; a < 4; a++) begin
      rate_d[a] = fin.zero[a] ? '0 : (fin.sat[a] ? '1 : fin.quo[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      bv_q    <= {bv_q[NB-2:0], !empty_i};
      out_v_q <= bv_q[NB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b0_neg_q  <= b0_neg_d;
      b0_mag_q  <= b0_mag_d;
      b0_dur_q  <= entry_i.dur;
      b0_mask_q <= entry_i.mv.mask;
      b1_neg_q  <= b0_neg_q;
      b1_lo_q   <= b1_lo_d;
      b1_hi_q   <= b1_hi_d;
      b1_dur_q  <= b0_dur_q;
      b1_mask_q <= b0_mask_q;
      b2_q      <= b2_d;
      rs_q      <= rs_d;
      time_q    <= fin.dur;
      steps_q   <= fin.steps;
      rate_q    <= rate_d;
      mask_q    <= fin.mask;
    end
  end

  assign out_valid_o      = out_v_q;
  assign move_time_o      = time_q;
  assign motor_a_steps_o  = steps_q[0];
  assign motor_a_rate_o   = rate_q[0];
  assign motor_b_steps_o  = steps_q[1];
  assign motor_b_rate_o   = rate_q[1];
  assign z_steps_o        = steps_q[2];
  assign z_rate_o         = rate_q[2];
  assign extruder_steps_o = steps_q[3];
  assign extruder_rate_o  = rate_q[3];
  assign valve_bits_o     = mask_q;

endmodule

FILE: design/corexy_move_to_motor_steps.sv
`timescale 1ns / 1ps
// throughput: one word per cycle when unstalled, set by the 32-stage duration
// divider and the 40-stage rate dividers, each retiring one quotient bit per stage
// reset: pipeline and queue empty, 16.16 steps-per-mm registers at 80, 400 and 100
// ----------------------------------------------------------------------------
// corexy_move_to_motor_steps
// Converts a planned move into duration, step counts and step rates for the
// CoreXY A and B motors, Z and the extruder.
// ----------------------------------------------------------------------------
module corexy_move_to_motor_steps (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cxy_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [31:0]           start_x_i,
  input  logic signed [31:0]           start_y_i,
  input  logic signed [31:0]           start_z_i,
  input  logic signed [31:0]           start_e_i,
  input  logic signed [31:0]           end_x_i,
  input  logic signed [31:0]           end_y_i,
  input  logic signed [31:0]           end_z_i,
  input  logic signed [31:0]           end_e_i,
  input  logic [31:0]                  path_length_i,
  input  logic [31:0]                  feed_speed_i,
  input  logic [7:0]                   nozzle_mask_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  move_time_o,
  output logic signed [31:0]           motor_a_steps_o,
  output logic [39:0]                  motor_a_rate_o,
  output logic signed [31:0]           motor_b_steps_o,
  output logic [39:0]                  motor_b_rate_o,
  output logic signed [31:0]           z_steps_o,
  output logic [39:0]                  z_rate_o,
  output logic signed [31:0]           extruder_steps_o,
  output logic [39:0]                  extruder_rate_o,
  output logic [7:0]                   valve_bits_o
);
  import cxy_pkg::*;

  spm_t     spm_q;
  logic     wr_en;
  q_wr_t    q_wr;
  q_entry_t f_entry, b_entry;
  logic     q_full, q_empty, q_pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spm_q.xy <= 32'd5242880;
      spm_q.z  <= 32'd26214400;
      spm_q.e  <= 32'd6553600;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_XY:  spm_q.xy <= pwdata;
        REG_Z:   spm_q.z  <= pwdata;
        REG_E:   spm_q.e  <= pwdata;
        default: spm_q    <= spm_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_XY:  prdata = spm_q.xy;
      REG_Z:   prdata = spm_q.z;
      REG_E:   prdata = spm_q.e;
      default: prdata = 32'h0;
    endcase
  end

  cxy_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .start_z_i     (start_z_i),
    .start_e_i     (start_e_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .end_z_i       (end_z_i),
    .end_e_i       (end_e_i),
    .path_length_i (path_length_i),
    .feed_speed_i  (feed_speed_i),
    .nozzle_mask_i (nozzle_mask_i),
    .wr_o          (q_wr),
    .full_i        (q_full),
    .entry_o       (f_entry)
  );

  cxy_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .entry_i (f_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (b_entry)
  );

  cxy_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .spm_i            (spm_q),
    .empty_i          (q_empty),
    .entry_i          (b_entry),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .move_time_o      (move_time_o),
    .motor_a_steps_o  (motor_a_steps_o),
    .motor_a_rate_o   (motor_a_rate_o),
    .motor_b_steps_o  (motor_b_steps_o),
    .motor_b_rate_o   (motor_b_rate_o),
    .z_steps_o        (z_steps_o),
    .z_rate_o         (z_rate_o),
    .extruder_steps_o (extruder_steps_o),
    .extruder_rate_o  (extruder_rate_o),
    .valve_bits_o     (valve_bits_o)
  );

endmodule

FILE: design/cxy_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cxy_checker
// Port-level checks on the result channel of the step converter.
// ----------------------------------------------------------------------------
module cxy_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [31:0]        move_time_o,
  input logic signed [31:0] motor_a_steps_o,
  input logic [39:0]        motor_a_rate_o,
  input logic signed [31:0] motor_b_steps_o,
  input logic [39:0]        motor_b_rate_o,
  input logic signed [31:0] z_steps_o,
  input logic [39:0]        z_rate_o,
  input logic signed [31:0] extruder_steps_o,
  input logic [39:0]        extruder_rate_o
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_word_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(move_time_o) && $stable(motor_a_rate_o)
      && $stable(extruder_steps_o))
    else $error("stalled result word changed");

  a_zero_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && move_time_o == 32'h0 |->
      motor_a_rate_o == 40'h0 && motor_b_rate_o == 40'h0 &&
      z_rate_o == 40'h0 && extruder_rate_o == 40'h0)
    else $error("nonzero rate with zero duration");

  a_zero_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (motor_a_steps_o != 32'sh0 || motor_a_rate_o == 40'h0) &&
      (motor_b_steps_o != 32'sh0 || motor_b_rate_o == 40'h0) &&
      (z_steps_o != 32'sh0 || z_rate_o == 40'h0) &&
      (extruder_steps_o != 32'sh0 || extruder_rate_o == 40'h0))
    else $error("nonzero rate with zero steps");

endmodule

bind corexy_move_to_motor_steps cxy_checker u_cxy_checker (.*);
